@@ design/crfd_pkg.sv @@
// Package for the checked record frame decoder: constants and types.
// No dependencies.
package crfd_pkg;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [7:0]  MAGIC_0   = 8'h46;
    localparam logic [7:0]  MAGIC_1   = 8'h53;
    localparam logic [7:0]  MAGIC_2   = 8'h49;
    localparam logic [7:0]  MAGIC_3   = 8'h32;
    localparam logic [15:0] HDR_LEN   = 16'd6;
    localparam logic [15:0] SUM_LEN   = 16'd4;

    localparam logic [1:0] REG_VERSION  = 2'd0;
    localparam logic [1:0] REG_MAX_REC  = 2'd1;
    localparam logic [1:0] REG_MAX_QTY  = 2'd2;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_CATALOG = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  data_byte;
        logic        frame_end;
        logic [5:0]  catalog_index;
        logic [15:0] catalog_id;
    } in_item_t;

    typedef struct packed {
        logic       frame_ok;
        logic [5:0] entry_index;
        logic [7:0] quantity;
        logic       last_result;
    } out_item_t;

    typedef struct packed {
        logic [1:0] index;
        logic [7:0] data;
    } cfg_item_t;

endpackage

@@ design/crfd_if.sv @@
// Valid/ready channel interfaces for items and configuration writes.
// Depends on crfd_pkg.
interface crfd_in_if
    import crfd_pkg::*;
();
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface crfd_out_if
    import crfd_pkg::*;
();
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface crfd_cfg_if
    import crfd_pkg::*;
();
    logic      valid;
    logic      ready;
    cfg_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ design/crfd_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module crfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ design/crfd_hash.sv @@
// FNV-1a step unit: one xor-multiply by the prime, result registered.
// Depends on crfd_pkg.
module crfd_hash
    import crfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        init,
    input  logic        step,
    input  logic [7:0]  byte_in,
    output logic [31:0] hash
);
    logic [31:0] hash_reg;
    logic [31:0] hash_next;

    always_comb
    begin
        hash_next = hash_reg;
        if (init)
        begin
            hash_next = FNV_BASIS;
        end
        else if (step)
        begin
            hash_next = (hash_reg ^ {24'd0, byte_in}) * FNV_PRIME;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= FNV_BASIS;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

    assign hash = hash_reg;
endmodule

@@ design/checked_record_frame_decoder.sv @@
// Checked record frame decoder: takes a frame one byte an item, checks header, length
// and FNV-1a checksum, and reports catalog quantities. A byte is taken only when the
// last is done; one that completes a record searches the catalog RAM one slot a cycle.
// An accepted frame answers with ITEM_COUNT results, one a cycle while the output is
// ready; a rejected one with a single failure result. No clearing pass: per-frame marks
// are flip-flops cleared as results go out, or all at once after a rejected frame.
module checked_record_frame_decoder
    import crfd_pkg::*;
#(
    parameter int ITEM_COUNT = 32
) (
    input logic     clk,
    input logic     rst_n,
    crfd_in_if.sink   in_ch,
    crfd_out_if.source out_ch,
    crfd_cfg_if.sink  cfg
);
    localparam int IW = (ITEM_COUNT > 1) ? $clog2(ITEM_COUNT) : 1;
    localparam logic [6:0] LAST_SLOT = 7'(ITEM_COUNT - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_BYTE   = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;
    localparam logic [2:0] S_FAIL   = 3'd5;

    logic [2:0]  state_reg;
    logic [7:0]  version_reg, maxrec_reg, maxqty_reg;
    logic [7:0]  trail_reg [4];
    logic [15:0] pos_reg;
    logic [7:0]  count_reg;
    logic [15:0] rec_id_reg;
    logic [7:0]  rec_qty_reg;
    logic [1:0]  phase_reg;
    logic [15:0] rec_end_reg;
    logic        err_reg;
    logic [7:0]  byte_reg;
    logic        end_reg;
    logic [6:0]  scan_reg;
    logic        rd_valid_reg;
    logic [IW-1:0] rd_slot_reg;
    logic [7:0]  qty_reg  [ITEM_COUNT];
    logic        seen_reg [ITEM_COUNT];

    logic        hash_init, hash_step;
    logic [31:0] hash;
    logic [15:0] ram_rdata;
    logic        ram_we;
    logic        in_fire;

    assign in_fire = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign ram_we = in_fire && in_ch.data.opcode == OP_CATALOG
                    && {1'b0, in_ch.data.catalog_index} < 7'(ITEM_COUNT);

    crfd_ram #(.WIDTH(16), .DEPTH(ITEM_COUNT)) u_ids (
        .clk(clk), .we(ram_we), .waddr(in_ch.data.catalog_index[IW-1:0]),
        .wdata(in_ch.data.catalog_id), .raddr(scan_reg[IW-1:0]), .rdata(ram_rdata)
    );

    assign hash_step = (state_reg == S_BYTE) && pos_reg >= SUM_LEN;
    assign hash_init = (state_reg == S_EMIT && scan_reg == LAST_SLOT && out_ch.ready)
                       || (state_reg == S_FAIL && out_ch.ready);

    crfd_hash u_hash (
        .clk(clk), .rst_n(rst_n), .init(hash_init), .step(hash_step),
        .byte_in(trail_reg[0]), .hash(hash)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg <= 8'd2;
            maxrec_reg  <= 8'd32;
            maxqty_reg  <= 8'd255;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                REG_VERSION: version_reg <= cfg.data.data;
                REG_MAX_REC: maxrec_reg  <= cfg.data.data;
                REG_MAX_QTY: maxqty_reg  <= cfg.data.data;
                default: ;
            endcase
        end
    end

    logic [31:0] stored;
    logic        ok;
    assign stored = {trail_reg[3], trail_reg[2], trail_reg[1], trail_reg[0]};
    assign ok = !err_reg && pos_reg >= HDR_LEN
                && pos_reg == HDR_LEN + 16'(count_reg) * 16'd3 + SUM_LEN
                && stored == hash;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pos_reg <= '0; count_reg <= '0; err_reg <= 1'b0; phase_reg <= '0;
            scan_reg <= '0; rd_valid_reg <= 1'b0; rd_slot_reg <= '0;
            byte_reg <= '0; end_reg <= 1'b0; rec_id_reg <= '0; rec_qty_reg <= '0;
            rec_end_reg <= HDR_LEN;
            for (int i = 0; i < 4; i++) trail_reg[i] <= '0;
            for (int i = 0; i < ITEM_COUNT; i++)
            begin
                qty_reg[i] <= '0; seen_reg[i] <= 1'b0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire && in_ch.data.opcode == OP_BYTE)
                    begin
                        byte_reg  <= in_ch.data.data_byte;
                        end_reg   <= in_ch.data.frame_end;
                        state_reg <= S_BYTE;
                    end
                end
                S_BYTE:
                begin
                    trail_reg[0] <= trail_reg[1];
                    trail_reg[1] <= trail_reg[2];
                    trail_reg[2] <= trail_reg[3];
                    trail_reg[3] <= byte_reg;
                    if ((pos_reg == 16'd0 && byte_reg != MAGIC_0)
                        || (pos_reg == 16'd1 && byte_reg != MAGIC_1)
                        || (pos_reg == 16'd2 && byte_reg != MAGIC_2)
                        || (pos_reg == 16'd3 && byte_reg != MAGIC_3)
                        || (pos_reg == 16'd4 && byte_reg != version_reg)
                        || (pos_reg == 16'd5 && byte_reg > maxrec_reg))
                    begin
                        err_reg <= 1'b1;
                    end
                    if (pos_reg == 16'd5)
                    begin
                        count_reg   <= byte_reg;
                        rec_end_reg <= HDR_LEN + 16'(byte_reg) * 16'd3;
                    end
                    if (pos_reg != 16'hFFFF) pos_reg <= pos_reg + 16'd1;
                    state_reg <= end_reg ? S_CHECK : S_IDLE;
                    if (pos_reg >= HDR_LEN && pos_reg < rec_end_reg)
                    begin
                        unique case (phase_reg)
                            2'd0: begin rec_id_reg[7:0] <= byte_reg; phase_reg <= 2'd1; end
                            2'd1: begin rec_id_reg[15:8] <= byte_reg; phase_reg <= 2'd2; end
                            default:
                            begin
                                rec_qty_reg  <= (byte_reg > maxqty_reg) ? maxqty_reg
                                                                        : byte_reg;
                                phase_reg    <= 2'd0;
                                scan_reg     <= '0;
                                rd_valid_reg <= 1'b0;
                                state_reg    <= S_SEARCH;
                            end
                        endcase
                    end
                end
                S_SEARCH:
                begin
                    // Read address runs one slot ahead of the compare.
                    rd_valid_reg <= scan_reg <= LAST_SLOT;
                    rd_slot_reg  <= scan_reg[IW-1:0];
                    scan_reg     <= scan_reg + 7'd1;
                    if (rd_valid_reg && ram_rdata == rec_id_reg)
                    begin
                        if (seen_reg[rd_slot_reg]) err_reg <= 1'b1;
                        else
                        begin
                            qty_reg[rd_slot_reg]  <= rec_qty_reg;
                            seen_reg[rd_slot_reg] <= 1'b1;
                        end
                        state_reg <= end_reg ? S_CHECK : S_IDLE;
                        scan_reg  <= '0;
                    end
                    else if (rd_valid_reg && 7'(rd_slot_reg) == LAST_SLOT)
                    begin
                        state_reg <= end_reg ? S_CHECK : S_IDLE;
                        scan_reg  <= '0;
                    end
                end
                S_CHECK:
                begin
                    scan_reg  <= '0;
                    state_reg <= ok ? S_EMIT : S_FAIL;
                end
                S_EMIT:
                begin
                    if (out_ch.ready)
                    begin
                        qty_reg[scan_reg[IW-1:0]]  <= '0;
                        seen_reg[scan_reg[IW-1:0]] <= 1'b0;
                        if (scan_reg == LAST_SLOT)
                        begin
                            for (int i = 0; i < 4; i++) trail_reg[i] <= '0;
                            pos_reg <= '0; count_reg <= '0; err_reg <= 1'b0;
                            phase_reg <= '0; scan_reg <= '0; rec_end_reg <= HDR_LEN;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            scan_reg <= scan_reg + 7'd1;
                        end
                    end
                end
                S_FAIL:
                begin
                    if (out_ch.ready)
                    begin
                        for (int i = 0; i < ITEM_COUNT; i++)
                        begin
                            qty_reg[i] <= '0; seen_reg[i] <= 1'b0;
                        end
                        for (int i = 0; i < 4; i++) trail_reg[i] <= '0;
                        pos_reg <= '0; count_reg <= '0; err_reg <= 1'b0;
                        phase_reg <= '0; scan_reg <= '0; rec_end_reg <= HDR_LEN;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid = (state_reg == S_EMIT) || (state_reg == S_FAIL);
    always_comb
    begin
        out_ch.data.frame_ok    = (state_reg == S_EMIT);
        out_ch.data.entry_index = (state_reg == S_EMIT) ? scan_reg[5:0] : 6'd0;
        out_ch.data.quantity    = (state_reg == S_EMIT) ? qty_reg[scan_reg[IW-1:0]] : 8'd0;
        out_ch.data.last_result = (state_reg == S_FAIL) || (scan_reg == LAST_SLOT);
    end

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !out_ch.valid)
        else $error("input ready while results pending");
    a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.data.frame_ok) |-> (out_ch.data.quantity == 8'd0
        && out_ch.data.last_result))
        else $error("malformed failure result");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
        else $error("result dropped while stalled");
`endif
endmodule
